// ===== rtl/gbp_pkg.sv =====
// Shared constants and types for the Goertzel bin power detector.
`timescale 1ns / 1ps

package gbp_pkg;

  // Defaults of the top-level parameters
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_BLOCK_DEF   = 4096;
  localparam int ACC_BITS_DEF    = 40;

  // Register widths
  localparam int COS_W     = 18;
  localparam int SIN_W     = 18;
  localparam int FB_W      = 19;
  localparam int BLEN_W    = 13;
  localparam int CFG_W     = 19;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COSINE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SINE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLEN     = 2'd3;

  // Register reset values
  localparam logic signed [COS_W-1:0] COS_RST  = 18'sd65536;
  localparam logic signed [SIN_W-1:0] SIN_RST  = 18'sd0;
  localparam logic signed [FB_W-1:0]  FB_RST   = 19'sd131072;
  localparam logic [BLEN_W-1:0]       BLEN_RST = 13'd256;

  // Datapath
  localparam int MUL_W      = 32;
  localparam int SPLIT      = 24;
  localparam int FRAC_BITS  = 16;
  localparam int ROUND_BIAS = 32768;
  localparam int POWER_W    = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_SUM,
    ST_ROUND,
    ST_APPLY,
    ST_ABS,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_SUM
  } state_t;

  // What a scaled product feeds once it is rounded
  typedef enum logic [1:0] {
    OP_REC,
    OP_COS,
    OP_SIN
  } op_t;

endpackage

// ===== rtl/goertzel_bin_power.sv =====
// Goertzel single-bin power detector built around one shared 32x32 multiplier.
`timescale 1ns / 1ps

// Channel | Direction | Ports                                    | Beat
// input   | in        | in_valid, in_stall, in_sample            | one sample
// result  | out       | out_valid, out_stall, out_bin_power,     | one block power
//         |           | out_power_saturated                      |
// config  | in        | cfg_we, cfg_index, cfg_wdata             | one register write
//
// A sample is taken in the accept cycle and then runs the recursion product (two
// partial products, sum, round, update) on the shared multiplier. The sample that
// ends a block then runs the cosine and sine products, magnitude, two squares and
// final sum, and waits there while the output register is stalled.
// rst_n is synchronous and clears registers, recursion state and the sequencer.
// A finished result waits in the output register; the next sample is taken meanwhile.

module goertzel_bin_power
  import gbp_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int ACC_BITS    = ACC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [POWER_W-1:0]            out_bin_power,
  output logic                          out_power_saturated,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int CMP_W = (CNT_W > BLEN_W) ? CNT_W : BLEN_W;
  localparam int NW    = ACC_BITS + 4;
  localparam int RW    = ACC_BITS + 2;
  localparam int AW    = (ACC_BITS + 19 > POWER_W + 1) ? ACC_BITS + 19 : POWER_W + 1;

  // Configuration
  logic signed [COS_W-1:0] cos_r;
  logic signed [SIN_W-1:0] sin_r;
  logic signed [FB_W-1:0]  fb_r;
  logic [BLEN_W-1:0]       blen_r;

  // Control state
  state_t                     state_r, state_nxt;
  logic signed [ACC_BITS-1:0] d1_r, d1_nxt;
  logic signed [ACC_BITS-1:0] d2_r, d2_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       satseen_r, satseen_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // Datapath
  op_t                  op_r, op_nxt;
  logic                 neg_r, neg_nxt;
  logic [FB_W-1:0]      a_r, a_nxt;
  logic [ACC_BITS-1:0]  b_r, b_nxt;
  logic signed [NW-1:0] base_r, base_nxt;
  logic [2*MUL_W-1:0]   prod_r, prod_nxt;
  logic [AW-1:0]        acc_r, acc_nxt;
  logic [RW-1:0]        rnd_r, rnd_nxt;
  logic [MUL_W-1:0]     mag_re_r, mag_re_nxt;
  logic [MUL_W-1:0]     mag_im_r, mag_im_nxt;
  logic                 big_r, big_nxt;
  logic [POWER_W-1:0]   out_power_r, out_power_nxt;
  logic                 out_sat_r, out_sat_nxt;

  // Combinational helpers
  logic [MUL_W-1:0]     mul_x, mul_y;
  logic [2*MUL_W-1:0]   mul_p;
  logic [COS_W-1:0]     cos_mag;
  logic [SIN_W-1:0]     sin_mag;
  logic [FB_W-1:0]      fb_mag;
  logic [ACC_BITS-1:0]  d1_mag;
  logic signed [NW-1:0] x_ext;
  logic signed [NW-1:0] rnd_ext;
  logic signed [NW-1:0] rec_sum;
  logic signed [NW-1:0] re_val;
  logic [NW-1:0]        re_mag;
  logic                 rec_ovf;
  logic [ACC_BITS-1:0]  rec_sat;
  logic [AW-1:0]        rnd_full;
  logic [CNT_W-1:0]     cnt_inc;
  logic [CMP_W-1:0]     blen_ext;
  logic [CMP_W-1:0]     len_eff;
  logic                 block_end;
  logic [POWER_W:0]     pw_sum;
  logic                 out_free;

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_bin_power       = out_power_r;
  assign out_power_saturated = out_sat_r;

  assign cos_mag = cos_r[COS_W-1] ? COS_W'(-cos_r) : COS_W'(cos_r);
  assign sin_mag = sin_r[SIN_W-1] ? SIN_W'(-sin_r) : SIN_W'(sin_r);
  assign fb_mag  = fb_r[FB_W-1] ? FB_W'(-fb_r) : FB_W'(fb_r);
  assign d1_mag  = d1_r[ACC_BITS-1] ? ACC_BITS'(-d1_r) : ACC_BITS'(d1_r);
  assign x_ext   = NW'(in_sample);
  assign rnd_ext = NW'(rnd_r);

  // Shared multiplier
  always_comb begin
    case (state_r)
      ST_MUL_LO: begin
        mul_x = MUL_W'(a_r);
        mul_y = MUL_W'(b_r[SPLIT-1:0]);
      end
      ST_SQ_RE: begin
        mul_x = mag_re_r;
        mul_y = mag_re_r;
      end
      ST_SQ_IM: begin
        mul_x = mag_im_r;
        mul_y = mag_im_r;
      end
      default: begin
        mul_x = MUL_W'(a_r);
        mul_y = MUL_W'(b_r[ACC_BITS-1:SPLIT]);
      end
    endcase
  end
  assign mul_p = mul_x * mul_y;

  // Recursion update and saturation to the accumulator range
  assign rec_sum = neg_r ? base_r - rnd_ext : base_r + rnd_ext;
  assign rec_ovf = !(&rec_sum[NW-1:ACC_BITS-1]) && (|rec_sum[NW-1:ACC_BITS-1]);
  assign rec_sat = rec_sum[NW-1] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                 : {1'b0, {(ACC_BITS-1){1'b1}}};

  assign re_val   = neg_r ? NW'(d1_r) + rnd_ext : NW'(d1_r) - rnd_ext;
  assign re_mag   = base_r[NW-1] ? NW'(-base_r) : NW'(base_r);
  assign rnd_full = (acc_r + AW'(ROUND_BIAS)) >> FRAC_BITS;

  // Block length: zero acts as one, clamp at the maximum block
  assign cnt_inc  = (cnt_r < CNT_W'(MAX_BLOCK)) ? cnt_r + CNT_W'(1) : cnt_r;
  assign blen_ext = CMP_W'(blen_r);
  always_comb begin
    if (blen_r == '0) begin
      len_eff = CMP_W'(1);
    end else if (blen_ext > CMP_W'(MAX_BLOCK)) begin
      len_eff = CMP_W'(MAX_BLOCK);
    end else begin
      len_eff = blen_ext;
    end
  end
  assign block_end = (CMP_W'(cnt_inc) >= len_eff);

  assign pw_sum   = {1'b0, acc_r[POWER_W-1:0]} + {1'b0, prod_r};
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    d1_nxt        = d1_r;
    d2_nxt        = d2_r;
    cnt_nxt       = cnt_r;
    satseen_nxt   = satseen_r;
    out_valid_nxt = out_valid_r && out_stall;
    op_nxt        = op_r;
    neg_nxt       = neg_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    base_nxt      = base_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    rnd_nxt       = rnd_r;
    mag_re_nxt    = mag_re_r;
    mag_im_nxt    = mag_im_r;
    big_nxt       = big_r;
    out_power_nxt = out_power_r;
    out_sat_nxt   = out_sat_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          base_nxt  = x_ext - NW'(d2_r);
          a_nxt     = fb_mag;
          b_nxt     = d1_mag;
          neg_nxt   = fb_r[FB_W-1] ^ d1_r[ACC_BITS-1];
          op_nxt    = OP_REC;
          state_nxt = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        prod_nxt  = mul_p;
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        acc_nxt   = AW'(prod_r);
        prod_nxt  = mul_p;
        state_nxt = ST_MUL_SUM;
      end
      ST_MUL_SUM: begin
        acc_nxt   = acc_r + (AW'(prod_r) << SPLIT);
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        rnd_nxt   = rnd_full[RW-1:0];
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        case (op_r)
          OP_REC: begin
            d2_nxt      = d1_r;
            d1_nxt      = rec_ovf ? rec_sat : rec_sum[ACC_BITS-1:0];
            satseen_nxt = satseen_r | rec_ovf;
            cnt_nxt     = cnt_inc;
            if (block_end) begin
              // old delay_one becomes delay_two: the operand of both products
              a_nxt     = FB_W'(cos_mag);
              b_nxt     = d1_mag;
              neg_nxt   = cos_r[COS_W-1] ^ d1_r[ACC_BITS-1];
              op_nxt    = OP_COS;
              state_nxt = ST_MUL_LO;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          OP_COS: begin
            base_nxt  = re_val;
            a_nxt     = FB_W'(sin_mag);
            neg_nxt   = sin_r[SIN_W-1] ^ d2_r[ACC_BITS-1];
            op_nxt    = OP_SIN;
            state_nxt = ST_MUL_LO;
          end
          default: begin
            // imaginary magnitude is the rounded product itself
            mag_im_nxt = rnd_r[MUL_W-1:0];
            big_nxt    = |rnd_r[RW-1:MUL_W];
            state_nxt  = ST_ABS;
          end
        endcase
      end
      ST_ABS: begin
        mag_re_nxt = re_mag[MUL_W-1:0];
        big_nxt    = big_r | (|re_mag[NW-1:MUL_W]);
        state_nxt  = ST_SQ_RE;
      end
      ST_SQ_RE: begin
        prod_nxt  = mul_p;
        state_nxt = ST_SQ_IM;
      end
      ST_SQ_IM: begin
        acc_nxt   = AW'(prod_r);
        prod_nxt  = mul_p;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_power_nxt = (big_r || pw_sum[POWER_W]) ? {POWER_W{1'b1}}
                                                     : pw_sum[POWER_W-1:0];
          out_sat_nxt   = satseen_r | big_r | pw_sum[POWER_W];
          d1_nxt        = '0;
          d2_nxt        = '0;
          cnt_nxt       = '0;
          satseen_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r  <= COS_RST;
      sin_r  <= SIN_RST;
      fb_r   <= FB_RST;
      blen_r <= BLEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COSINE:   cos_r  <= cfg_wdata[COS_W-1:0];
        REG_SINE:     sin_r  <= cfg_wdata[SIN_W-1:0];
        REG_FEEDBACK: fb_r   <= cfg_wdata[FB_W-1:0];
        REG_BLEN:     blen_r <= cfg_wdata[BLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      d1_r        <= '0;
      d2_r        <= '0;
      cnt_r       <= '0;
      satseen_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      d1_r        <= d1_nxt;
      d2_r        <= d2_nxt;
      cnt_r       <= cnt_nxt;
      satseen_r   <= satseen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    neg_r       <= neg_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    base_r      <= base_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    rnd_r       <= rnd_nxt;
    mag_re_r    <= mag_re_nxt;
    mag_im_r    <= mag_im_nxt;
    big_r       <= big_nxt;
    out_power_r <= out_power_nxt;
    out_sat_r   <= out_sat_nxt;
  end

endmodule

// ===== rtl/gbp_checker.sv =====
// Port-level checks for the Goertzel bin power detector, bound to the top level.
`timescale 1ns / 1ps

module gbp_checker
  import gbp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [POWER_W-1:0] out_bin_power,
  input logic               out_power_saturated
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bin_power)
                               && $stable(out_power_saturated))
    else $error("result beat changed while stalled");

  // A sample occupies the sequencer for the following cycles
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("sample channel not stalled after a sample was taken");

  // A result is only produced while a sample is being worked on
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a sample in progress");

  // Reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind goertzel_bin_power gbp_checker u_gbp_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the Goertzel bin power detector.
`timescale 1ns / 1ps

module tb;
  import gbp_pkg::*;

  localparam int SW             = SAMPLE_BITS_DEF;
  localparam int SETTLE_CYCLES  = 24;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 560;
  localparam int LONG_PART      = 96;
  localparam longint ACC_HI = (longint'(1) <<< (ACC_BITS_DEF - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef struct packed {
    logic [POWER_W-1:0] power;
    logic               saturated;
  } bin_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_SPARSE,
    STALL_SOLID
  } stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [SW-1:0] in_sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [POWER_W-1:0]   out_bin_power;
  logic                 out_power_saturated;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_COSINE;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Predictor copy of the registers and recursion state
  logic signed [COS_W-1:0]        cos_q16 = COS_RST;
  logic signed [SIN_W-1:0]        sin_q16 = SIN_RST;
  logic signed [FB_W-1:0]         twice_cos_q16 = FB_RST;
  logic [BLEN_W-1:0]              span_reg = BLEN_RST;
  logic signed [ACC_BITS_DEF-1:0] tap_one = '0;
  logic signed [ACC_BITS_DEF-1:0] tap_two = '0;
  int unsigned                    taken = 0;
  bit                             clipped = 1'b0;

  bin_result_t power_due[$];
  int          failures = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  goertzel_bin_power u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_bin_power       (out_bin_power),
    .out_power_saturated (out_power_saturated),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Product scaled down by 2^16, nearest, ties away from zero
  function automatic longint q16_scale(input longint a, input longint b);
    longint p;
    longint m;
    p = a * b;
    m = ((p < 0) ? -p : p) + 64'sd32768;
    m = m >>> 16;
    return (p < 0) ? -m : m;
  endfunction

  // Square with the carry bit set when it no longer fits in 64 bits
  function automatic logic [POWER_W:0] square_capped(input longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    if (m >= 64'h1_0000_0000) return {1'b1, {POWER_W{1'b1}}};
    return {1'b0, m * m};
  endfunction

  task automatic advance_bin(input logic signed [SW-1:0] x);
    longint            acc;
    longint            re;
    longint            im;
    int unsigned       span;
    logic [POWER_W:0]  sq_re;
    logic [POWER_W:0]  sq_im;
    logic [POWER_W:0]  total;
    bin_result_t       res;
    acc = q16_scale(longint'(twice_cos_q16), longint'(tap_one)) - longint'(tap_two)
          + longint'(x);
    if (acc > ACC_HI) begin
      acc = ACC_HI;
      clipped = 1'b1;
    end else if (acc < ACC_LO) begin
      acc = ACC_LO;
      clipped = 1'b1;
    end
    tap_two = tap_one;
    tap_one = acc[ACC_BITS_DEF-1:0];
    if (taken < MAX_BLOCK_DEF) taken++;
    span = (span_reg == 0) ? 1 : int'(span_reg);
    if (span > MAX_BLOCK_DEF) span = MAX_BLOCK_DEF;
    if (taken >= span) begin
      re = longint'(tap_one) - q16_scale(longint'(cos_q16), longint'(tap_two));
      im = q16_scale(longint'(sin_q16), longint'(tap_two));
      sq_re = square_capped(re);
      sq_im = square_capped(im);
      total = {1'b0, sq_re[POWER_W-1:0]} + {1'b0, sq_im[POWER_W-1:0]};
      res.saturated = clipped | sq_re[POWER_W] | sq_im[POWER_W] | total[POWER_W];
      res.power = total[POWER_W] ? {POWER_W{1'b1}} : total[POWER_W-1:0];
      power_due.push_back(res);
      tap_one = '0;
      tap_two = '0;
      taken = 0;
      clipped = 1'b0;
    end
  endtask

  // Watch every channel at the clock edge, before the design's outputs move
  always @(posedge clk) begin
    bin_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (power_due.size() == 0) begin
          $error("result beat with no block pending: bin_power %0d", out_bin_power);
          failures++;
        end else begin
          want = power_due.pop_front();
          if (out_bin_power !== want.power) begin
            $error("bin_power: expected %0d, got %0d", want.power, out_bin_power);
            failures++;
          end
          if (out_power_saturated !== want.saturated) begin
            $error("power_saturated: expected %0b, got %0b", want.saturated,
                   out_power_saturated);
            failures++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_COSINE:   cos_q16 = cfg_wdata[COS_W-1:0];
          REG_SINE:     sin_q16 = cfg_wdata[SIN_W-1:0];
          REG_FEEDBACK: twice_cos_q16 = cfg_wdata[FB_W-1:0];
          REG_BLEN:     span_reg = cfg_wdata[BLEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) advance_bin(in_sample);
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // Receiver: switch between free flow, coin-toss, sparse and solid stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(4, 40);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_COIN:   out_stall <= 1'($urandom_range(0, 1));
      STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
      default:      out_stall <= (stall_left > 8);
    endcase
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic signed [SW-1:0] pick_sample();
    logic signed [SW-1:0] s;
    s = SW'($urandom);
    case ($urandom_range(0, 3))
      0: s = s >>> $urandom_range(1, 14);
      1: s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: ;
    endcase
    return s;
  endfunction

  // Send one sample beat; hold it until taken, then maybe idle for a while
  task automatic send_sample(input logic signed [SW-1:0] s);
    int gap;
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (power_due.size() != 0) @(posedge clk);
  endtask

  // Quiesce, let any sample in flight finish, then write all four registers
  task automatic set_config(input logic signed [COS_W-1:0] cos_v,
                            input logic signed [SIN_W-1:0] sin_v,
                            input logic signed [FB_W-1:0] fb_v,
                            input logic [BLEN_W-1:0] len_v);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_COSINE;
    cfg_wdata <= CFG_W'(cos_v);
    @(posedge clk);
    cfg_index <= REG_SINE;
    cfg_wdata <= CFG_W'(sin_v);
    @(posedge clk);
    cfg_index <= REG_FEEDBACK;
    cfg_wdata <= CFG_W'(fb_v);
    @(posedge clk);
    cfg_index <= REG_BLEN;
    cfg_wdata <= CFG_W'(len_v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Part of a block under the reset settings, then a shorter length ends it
  task automatic test_reset_state();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    set_config(COS_RST, SIN_RST, FB_RST, 13'd2);
    send_sample(16'sh1234);
  endtask

  task automatic test_zero_length();
    set_config(18'sd0, 18'sd65536, 19'sd0, 13'd0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
  endtask

  // New coefficients and a length already passed take effect mid-block
  task automatic test_mid_block_change();
    set_config(18'sd46341, 18'sd46341, 19'sd92682, 13'd16);
    repeat (3) send_sample(pick_sample());
    set_config(-18'sd65536, 18'sd0, -19'sd131072, 13'd2);
    send_sample(pick_sample());
  endtask

  task automatic test_coefficient_extremes();
    set_config(18'sh1FFFF, 18'sh20000, 19'sh40000, 13'd2);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
  endtask

  // Runaway recursion: clips the state and the power
  task automatic test_saturation();
    set_config(18'sh20000, 18'sh1FFFF, 19'sh3FFFF, 13'd16);
    repeat (16) send_sample(16'sh7FFF);
  endtask

  // Long block lengths, the maximum and a value above it, keep the block open;
  // a shorter length then closes it on the next sample
  task automatic test_longest_blocks();
    set_config(18'sd0, 18'sd65536, 19'sd0, 13'd4096);
    repeat (LONG_PART) send_sample(pick_sample());
    set_config(18'sd50000, -18'sd42000, 19'sd100000, 13'h1FFF);
    repeat (LONG_PART) send_sample(pick_sample());
    set_config(18'sd50000, -18'sd42000, 19'sd100000, 13'd100);
    send_sample(pick_sample());
  endtask

  // Mostly whole blocks on well-formed coefficients, some partial blocks and
  // arbitrary coefficients
  task automatic test_random_traffic();
    int sent;
    int cos_i;
    int sin_i;
    int len_i;
    int span;
    int count;
    logic signed [FB_W-1:0] fb_v;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      cos_i = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 262143)) - 131072
                                          : int'($urandom_range(0, 131072)) - 65536;
      sin_i = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 262143)) - 131072
                                          : int'($urandom_range(0, 131072)) - 65536;
      fb_v = ($urandom_range(0, 3) != 0) ? FB_W'(2 * cos_i) : FB_W'($urandom);
      case ($urandom_range(0, 19))
        0: len_i = 0;
        1: len_i = $urandom_range(25, 64);
        default: len_i = $urandom_range(1, 24);
      endcase
      set_config(COS_W'(cos_i), SIN_W'(sin_i), fb_v, BLEN_W'(len_i));
      span = (len_i == 0) ? 1 : len_i;
      count = span * $urandom_range(1, 3);
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, span);
      repeat (count) send_sample(pick_sample());
      sent += count;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_zero_length();
    test_mid_block_change();
    test_coefficient_extremes();
    test_saturation();
    test_longest_blocks();
    test_random_traffic();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (power_due.size() != 0) begin
      $error("%0d block results never arrived", power_due.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
